// File: rtl/core/jac_pkg.sv
// jac_pkg: shared types and constants for the joystick axis conditioner.
// No dependencies; used by joystick_axis_conditioner and its checker.
package jac_pkg;

    // Field widths
    localparam int SAMPLE_W   = 12;
    localparam int CENTER_W   = 12;
    localparam int DEADZONE_W = 9;
    localparam int AXIS_W     = 2;
    localparam int POS_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Stream data widths, rounded up to whole bytes
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 16;

    // Filter depth default and legal range
    localparam int TAPS_DEFAULT = 5;
    localparam int TAPS_MIN     = 2;
    localparam int TAPS_MAX     = 16;

    // Reset values
    localparam logic [SAMPLE_W-1:0]   HIST_RESET     = 12'd2047;
    localparam logic [CENTER_W-1:0]   CENTER_RESET   = 12'd2047;
    localparam logic [DEADZONE_W-1:0] DEADZONE_RESET = 9'd30;
    localparam logic                  INVERT_RESET   = 1'b0;
    localparam logic [AXIS_W-1:0]     AXIS_RESET     = 2'd0;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER   = 2'd0,
        CFG_DEADZONE = 2'd1,
        CFG_INVERT   = 2'd2,
        CFG_AXIS     = 2'd3
    } t_cfg_idx;

endpackage

// File: rtl/core/joystick_axis_conditioner.sv
// joystick_axis_conditioner: top level of the joystick axis conditioner.
// Depends on jac_pkg for widths, reset values and register indexes.
//
// Accepts one 12-bit ADC sample per clock while ready and keeps a moving
// average over the last TAPS samples (a shift line plus a running sum, both
// starting at mid-scale). The average is centered, divided by 8 toward zero,
// optionally negated and forced to zero inside the deadzone. A result goes
// out unless the previous value was zero, so the first zero after motion is
// reported and the very first sample always is. An input transfer loads the
// running sum; the average register and then the result register follow.
// Throughput is one sample per cycle through the three-stage pipeline
// (running sum, reciprocal multiply for the average, scale and deadzone)
// while the output is not stalled. Each stage moves on when the next one is
// free, so bubbles from suppressed results are squeezed out; while a result
// waits in the output register the two earlier stages still take up to two
// more samples before the input stalls. Configuration writes take effect on
// the next cycle and should be made while idle.
module joystick_axis_conditioner #(
    parameter int TAPS = jac_pkg::TAPS_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port
    input  logic                            i_cfg_we,
    input  logic [jac_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [jac_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Sample stream in
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [jac_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,  // [11:0] sample
    // Result stream out
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [jac_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,  // [10:0] position
    output logic [jac_pkg::AXIS_W-1:0]      o_m_axis_tuser   // [1:0] axis
);

    // Derived sizes: running sum and exact reciprocal for the divide by TAPS
    localparam int TAP_BITS = $clog2(TAPS);
    localparam int SUM_W    = jac_pkg::SAMPLE_W + TAP_BITS;
    localparam int SHIFT    = SUM_W + TAP_BITS;
    localparam int RECIP_W  = SUM_W + 1;
    localparam int PROD_W   = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(TAPS) - 64'd1) / 64'(TAPS));
    localparam logic [SUM_W-1:0] SUM_RESET =
        SUM_W'(TAPS * int'(jac_pkg::HIST_RESET));
    localparam int DIFF_W   = jac_pkg::SAMPLE_W + 1;

    // Configuration registers
    logic [jac_pkg::CENTER_W-1:0]   r_center;
    logic [jac_pkg::DEADZONE_W-1:0] r_deadzone;
    logic                           r_invert;
    logic [jac_pkg::AXIS_W-1:0]     r_axis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center   <= jac_pkg::CENTER_RESET;
            r_deadzone <= jac_pkg::DEADZONE_RESET;
            r_invert   <= jac_pkg::INVERT_RESET;
            r_axis     <= jac_pkg::AXIS_RESET;
        end else if (i_cfg_we) begin
            unique case (jac_pkg::t_cfg_idx'(i_cfg_idx))
                jac_pkg::CFG_CENTER:   r_center   <= i_cfg_data[jac_pkg::CENTER_W-1:0];
                jac_pkg::CFG_DEADZONE: r_deadzone <= i_cfg_data[jac_pkg::DEADZONE_W-1:0];
                jac_pkg::CFG_INVERT:   r_invert   <= i_cfg_data[0];
                jac_pkg::CFG_AXIS:     r_axis     <= i_cfg_data[jac_pkg::AXIS_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline occupancy and per-stage advance
    logic r_v1, r_v2, r_out_valid;
    logic ready1, ready2, ready3;
    logic s_xfer;

    assign ready3          = !r_out_valid || i_m_axis_tready;
    assign ready2          = !r_v2 || ready3;
    assign ready1          = !r_v1 || ready2;
    assign o_s_axis_tready = ready1;
    assign s_xfer          = i_s_axis_tvalid && ready1;

    // Stage 1: sample shift line and running sum (the sum is the stage payload)
    logic [jac_pkg::SAMPLE_W-1:0] r_hist [TAPS];
    logic [SUM_W-1:0]             r_sum;
    logic [SUM_W-1:0]             n_sum;
    logic [jac_pkg::SAMPLE_W-1:0] sample;

    assign sample = i_s_axis_tdata[jac_pkg::SAMPLE_W-1:0];
    assign n_sum  = r_sum - SUM_W'(r_hist[TAPS-1]) + SUM_W'(sample);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TAPS; i++) begin
                r_hist[i] <= jac_pkg::HIST_RESET;
            end
            r_sum <= SUM_RESET;
            r_v1  <= 1'b0;
        end else begin
            if (s_xfer) begin
                r_hist[0] <= sample;
                for (int i = 1; i < TAPS; i++) begin
                    r_hist[i] <= r_hist[i-1];
                end
                r_sum <= n_sum;
            end
            if (ready1) begin
                r_v1 <= i_s_axis_tvalid;
            end
        end
    end

    // Stage 2: average = floor(sum / TAPS) by reciprocal multiply
    logic [PROD_W-1:0]            prod;
    logic [jac_pkg::SAMPLE_W-1:0] r_avg;

    assign prod = PROD_W'(r_sum) * PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (ready2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready2 && r_v1) begin
            r_avg <= prod[SHIFT +: jac_pkg::SAMPLE_W];
        end
    end

    // Stage 3: center, divide by 8 toward zero, invert, deadzone
    logic signed [DIFF_W-1:0]        diff;
    logic signed [DIFF_W-1:0]        diff_adj;
    logic signed [DIFF_W-1:0]        quot;
    logic signed [jac_pkg::POS_W-1:0] scaled;
    logic signed [jac_pkg::POS_W-1:0] signed_val;
    logic        [jac_pkg::POS_W-1:0] mag;
    logic signed [jac_pkg::POS_W-1:0] pos;

    always_comb begin
        diff       = signed'({1'b0, r_avg}) - signed'({1'b0, r_center});
        diff_adj   = diff[DIFF_W-1] ? diff + DIFF_W'(7) : diff;
        quot       = diff_adj >>> 3;
        scaled     = quot[jac_pkg::POS_W-1:0];
        signed_val = r_invert ? -scaled : scaled;
        mag        = signed_val[jac_pkg::POS_W-1] ? unsigned'(-signed_val)
                                                  : unsigned'(signed_val);
        pos        = (mag < jac_pkg::POS_W'(r_deadzone)) ? '0 : signed_val;
    end

    // Output register and zero-run tracking
    logic                        r_last_zero;
    logic [jac_pkg::POS_W-1:0]   r_pos;
    logic [jac_pkg::AXIS_W-1:0]  r_out_axis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_last_zero <= 1'b0;
        end else if (ready3) begin
            r_out_valid <= r_v2 && !r_last_zero;
            if (r_v2) begin
                r_last_zero <= (pos == '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready3 && r_v2) begin
            r_pos      <= pos;
            r_out_axis <= r_axis;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(jac_pkg::M_TDATA_W - jac_pkg::POS_W){1'b0}}, r_pos};
    assign o_m_axis_tuser  = r_out_axis;

endmodule

// File: rtl/core/jac_checker.sv
// jac_checker: port-level assertions for joystick_axis_conditioner.
// Depends on jac_pkg; attached to the top level by the bind at the end.
module jac_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_s_axis_tready,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [jac_pkg::M_TDATA_W-1:0]  o_m_axis_tdata,
    input logic [jac_pkg::AXIS_W-1:0]     o_m_axis_tuser
);

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // Pipeline is empty after a reset edge, so the input side is ready
    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_axis_tready)
        else $error("input not ready after reset");

    // Position stays within -512..511 and padding bits are zero
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[15:11] == 5'd0)
                            && (o_m_axis_tdata[10] == o_m_axis_tdata[9]))
        else $error("position out of range");

    // A stalled result holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind joystick_axis_conditioner jac_checker u_jac_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
